[rtl/core/rgb_tint_temperature_contrast_assert.svh]
`ifndef RGB_TINT_TEMPERATURE_CONTRAST_ASSERT_SVH
`define RGB_TINT_TEMPERATURE_CONTRAST_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define RGBTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication checked on every rising edge outside reset.
`define RGBTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/rgbtc_pkg.sv]
package rgbtc_pkg;

  localparam int unsigned PIX_W = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_HUE      = 2'd0;
  localparam logic [1:0] CFG_IDX_TEMP     = 2'd1;
  localparam logic [1:0] CFG_IDX_CONTRAST = 2'd2;

  // Lane step width: step * 10, up to 20 * 128
  localparam int unsigned STEP_W = 13;

  typedef struct packed {
    logic [PIX_W-1:0] ch0_in;
    logic [PIX_W-1:0] ch1_in;
    logic [PIX_W-1:0] ch2_in;
  } rgbtc_pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] ch0_out;
    logic [PIX_W-1:0] ch1_out;
    logic [PIX_W-1:0] ch2_out;
  } rgbtc_pix_out_t;

  // Sine table: entry i is sin(i * 0.01255) in Q1.15
  localparam int unsigned SIN_ENTRIES  = 256;
  localparam int unsigned SIN_W        = 16;
  localparam int unsigned SIN_ROM_BITS = SIN_ENTRIES * SIN_W;

  localparam logic [63:0] ANGLE_STEP_Q30 = 64'd13475460;
  localparam logic [63:0] PI_Q30         = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  // Evaluated once at elaboration to fill the table
  function automatic logic [SIN_ROM_BITS-1:0] build_sin_rom();
    logic [SIN_ROM_BITS-1:0] rom;
    logic [63:0]             x;
    logic [63:0]             x2;
    logic [63:0]             term;
    logic signed [63:0]      sum;
    logic [63:0]             q;
    logic                    neg;
    logic [SIN_W-1:0]        entry;
    int                      i;
    int                      n;
    rom = '0;
    for (i = 0; i < SIN_ENTRIES; i++) begin
      x   = 64'(i) * ANGLE_STEP_Q30;
      neg = 1'b0;
      if (x > PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end else if (x > HALF_PI_Q30) begin
        x = PI_Q30 - x;
      end
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          7:       term = term / 64'd210;
          8:       term = term / 64'd272;
          9:       term = term / 64'd342;
          default: term = term / 64'd420;
        endcase
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      q = ($unsigned(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      entry = neg ? (16'd0 - q[SIN_W-1:0]) : q[SIN_W-1:0];
      rom[i*SIN_W +: SIN_W] = entry;
    end
    return rom;
  endfunction

  localparam logic [SIN_ROM_BITS-1:0] SIN_ROM = build_sin_rom();

endpackage

[rtl/core/rgb_tint_temperature_contrast.sv]
// Tint, colour temperature and contrast adjust for one 8-bit three-channel
// pixel per request. Each channel runs in its own lane: a tint curve, a
// temperature curve (each adds trunc(sin(v * 0.01255) * step * 10) and clamps
// to 0..255, sine from a 256-entry Q1.15 table), then a contrast curve about
// mid-grey. One request is taken every clock while in_stall_o is low; the
// result passes three register stages per curve (table read, multiply,
// round and clamp; multiply, divide by 200, clamp). The whole pipe
// advances together: while a result waits at the output with out_stall_i high,
// in_stall_o is raised in the same cycle and every stage holds. Configuration
// writes take effect at once and are meant for an empty pipe; writes to an
// index above the contrast register are dropped.
module rgb_tint_temperature_contrast
  import rgbtc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rgbtc_pix_in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rgbtc_pix_out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_wdata_i
);

`include "rgb_tint_temperature_contrast_assert.svh"

  localparam int unsigned LANES = 3;
  localparam int unsigned DEPTH = 9;

  logic [7:0] hue_q, temp_q, contrast_q;
  logic [7:0] hue_d, temp_d, contrast_d;

  logic signed [STEP_W-1:0] hue_ext, hue10, temp_ext, temp10;
  logic signed [STEP_W-1:0] tint_step [LANES];
  logic signed [STEP_W-1:0] temp_step [LANES];
  logic signed [8:0]        gain;

  logic [PIX_W-1:0] chan_in   [LANES];
  logic [PIX_W-1:0] tint_res  [LANES];
  logic [PIX_W-1:0] temp_res  [LANES];
  logic [PIX_W-1:0] chan_out  [LANES];

  logic [DEPTH-1:0] vld_d, vld_q;
  logic             en;
  logic             in_acc, out_acc;

  // Configuration registers
  always_comb begin
    hue_d      = hue_q;
    temp_d     = temp_q;
    contrast_d = contrast_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_HUE:      hue_d      = cfg_wdata_i;
        CFG_IDX_TEMP:     temp_d     = cfg_wdata_i;
        CFG_IDX_CONTRAST: contrast_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q      <= '0;
      temp_q     <= '0;
      contrast_q <= '0;
    end else begin
      hue_q      <= hue_d;
      temp_q     <= temp_d;
      contrast_q <= contrast_d;
    end
  end

  // Lane steps, already scaled by ten: tint +h, -h, +h; temperature -2T, +T, +T
  assign hue_ext  = {{(STEP_W-8){hue_q[7]}}, hue_q};
  assign temp_ext = {{(STEP_W-8){temp_q[7]}}, temp_q};
  assign hue10    = (hue_ext <<< 3) + (hue_ext <<< 1);
  assign temp10   = (temp_ext <<< 3) + (temp_ext <<< 1);

  assign tint_step[0] = hue10;
  assign tint_step[1] = -hue10;
  assign tint_step[2] = hue10;
  assign temp_step[0] = -(temp10 <<< 1);
  assign temp_step[1] = temp10;
  assign temp_step[2] = temp10;

  assign gain = 9'sd100 + $signed({contrast_q[7], contrast_q});

  // Pipe control: advance unless a finished result is held at the output
  assign en         = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;
  assign out_acc    = out_valid_o && !out_stall_i;

  assign vld_d = en ? {vld_q[DEPTH-2:0], in_valid_i} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign chan_in[0] = in_data_i.ch0_in;
  assign chan_in[1] = in_data_i.ch1_in;
  assign chan_in[2] = in_data_i.ch2_in;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    rgbtc_offset u_tint (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (chan_in[k]),
      .step_i (tint_step[k]),
      .res_o  (tint_res[k])
    );

    rgbtc_offset u_temp (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (tint_res[k]),
      .step_i (temp_step[k]),
      .res_o  (temp_res[k])
    );

    rgbtc_contrast u_contrast (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (temp_res[k]),
      .gain_i (gain),
      .res_o  (chan_out[k])
    );
  end

  // Merge the lanes into one result
  assign out_valid_o        = vld_q[DEPTH-1];
  assign out_data_o.ch0_out = chan_out[0];
  assign out_data_o.ch1_out = chan_out[1];
  assign out_data_o.ch2_out = chan_out[2];

  // Stall towards the source only ever comes from a held result
  `RGBTC_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled with no held result")

  // Requests in flight change only by accepts and deliveries
  `RGBTC_ASSERT_IMP(a_occupancy, $past(rst_ni), $countones(vld_q) == ($past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc))), "pipe occupancy out of step with handshakes")

endmodule

[rtl/core/rgbtc_offset.sv]
module rgbtc_offset
  import rgbtc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [PIX_W-1:0]         v_i,
  input  logic signed [STEP_W-1:0] step_i,
  output logic [PIX_W-1:0]         res_o
);

`include "rgb_tint_temperature_contrast_assert.svh"

  localparam int unsigned PROD_W = SIN_W + STEP_W;

  logic [PIX_W-1:0]         v1_q, v2_q, res_q;
  logic signed [SIN_W-1:0]  sin1_q;
  logic signed [PROD_W-1:0] prod2_d, prod2_q;
  logic signed [PROD_W-1:0] adj;
  logic signed [PROD_W-16:0] delta;
  logic signed [PIX_W+6:0]  sum;
  logic [PIX_W-1:0]         res_d;

  // Stage 2: sine times scaled step
  assign prod2_d = PROD_W'(sin1_q) * PROD_W'(step_i);

  // Stage 3: truncate toward zero, add, clamp
  always_comb begin
    adj   = prod2_q + (prod2_q[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    delta = adj[PROD_W-1:15];
    sum   = $signed({7'd0, v2_q}) + (PIX_W+7)'(delta);
    priority if (sum < 0) begin
      res_d = '0;
    end else if (sum > $signed(15'd255)) begin
      res_d = '1;
    end else begin
      res_d = sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q    <= v_i;
      sin1_q  <= SIN_ROM[{v_i, 4'd0} +: SIN_W];
      v2_q    <= v1_q;
      prod2_q <= prod2_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  // A zero step leaves the value untouched
  `RGBTC_ASSERT_IMP(a_zero_step_ident, $past(rst_ni, 3) && $past(en_i, 1) && $past(en_i, 2) && $past(en_i, 3) && ($past(step_i, 2) == '0), res_o == $past(v_i, 3), "offset curve with zero step changed the value")

endmodule

[rtl/core/rgbtc_contrast.sv]
module rgbtc_contrast
  import rgbtc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [PIX_W-1:0]  v_i,
  input  logic signed [8:0] gain_i,
  output logic [PIX_W-1:0]  res_o
);

`include "rgb_tint_temperature_contrast_assert.svh"

  logic signed [9:0]  diff;
  logic signed [18:0] prod1_d, prod1_q;
  logic signed [19:0] num;
  logic [12:0]        quot8;
  logic [25:0]        mul2_d, mul2_q;
  logic               neg2_q, sat2_q;
  logic [PIX_W-1:0]   res_d, res_q;

  // Stage 1: (2v - 255) * (100 + C)
  assign diff    = $signed({1'b0, v_i, 1'b0}) - 10'sd255;
  assign prod1_d = 19'(diff) * 19'(gain_i);

  // Stage 2: offset, then divide by 200 as (n >> 3) * 5243 >> 17
  assign num    = 20'(prod1_q) + 20'sd25500;
  assign quot8  = num[15:3];
  assign mul2_d = 26'(quot8) * 26'd5243;

  // Stage 3: clamp
  always_comb begin
    priority if (neg2_q) begin
      res_d = '0;
    end else if (sat2_q) begin
      res_d = '1;
    end else begin
      res_d = mul2_q[24:17];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      mul2_q  <= mul2_d;
      neg2_q  <= num[19];
      sat2_q  <= (num >= 20'sd51200);
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  // Unity gain is the identity curve
  `RGBTC_ASSERT_IMP(a_unity_ident, $past(rst_ni, 3) && $past(en_i, 1) && $past(en_i, 2) && $past(en_i, 3) && ($past(gain_i, 3) == 9'sd100), res_o == $past(v_i, 3), "contrast curve at unity gain changed the value")

endmodule
